[hdl/qte_pkg.sv]
package qte_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int ATAN_ENTRIES = 24;

  localparam int QW  = 16;  // quaternion component width
  localparam int PW  = 32;  // product width
  localparam int SW  = 34;  // atan2 operand width from the products
  localparam int SPW = 30;  // clamped pitch sine, Q.28 within +-1.0
  localparam int MW  = 29;  // magnitude of the pitch sine
  localparam int RW  = 57;  // 1 - s^2 in Q.56
  localparam int RTW = 29;  // square root, Q.28
  localparam int DW  = 36;  // CORDIC x/y
  localparam int AW  = 24;  // CORDIC angle, Q.20
  localparam int OW  = 16;  // Q3.13 angle

  localparam int FRONT_STAGES = 4;
  localparam int ISQ_STAGES   = RTW;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int PIPE_DEPTH   = FRONT_STAGES + ISQ_STAGES + CORDIC_LAT + 1;

  localparam logic signed [SW-1:0] ONE_Q28     = SW'(64'sd268435456);
  localparam logic signed [AW-1:0] PI_Q20      = AW'(3294199);
  localparam logic signed [AW-1:0] HALF_PI_Q20 = AW'(1647099);
  localparam logic signed [OW-1:0] PI_Q13      = OW'(25736);
  localparam logic signed [OW-1:0] HALF_PI_Q13 = OW'(12868);

  function automatic logic signed [AW-1:0] atan_q20(input logic [4:0] idx);
    logic signed [AW-1:0] a;
    case (idx)
      5'd0:  a = AW'(823550);
      5'd1:  a = AW'(486170);
      5'd2:  a = AW'(256879);
      5'd3:  a = AW'(130396);
      5'd4:  a = AW'(65451);
      5'd5:  a = AW'(32757);
      5'd6:  a = AW'(16383);
      5'd7:  a = AW'(8192);
      5'd8:  a = AW'(4096);
      5'd9:  a = AW'(2048);
      5'd10: a = AW'(1024);
      5'd11: a = AW'(512);
      5'd12: a = AW'(256);
      5'd13: a = AW'(128);
      5'd14: a = AW'(64);
      5'd15: a = AW'(32);
      5'd16: a = AW'(16);
      5'd17: a = AW'(8);
      5'd18: a = AW'(4);
      5'd19: a = AW'(2);
      5'd20: a = AW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[hdl/quaternion_to_euler_angles_top.sv]
// Unit quaternion (Q2.14) to roll, yaw (Q3.13 radians) and pitch (Q2.13 radians). Fully pipelined:
// one item may enter every clock while the output is not stalled; it passes 4 product/sum stages,
// 29 square-root stages for the pitch cosine, 16 CORDIC stages and one output stage.
// The whole pipe advances together; it holds while a result is stalled at the output
// and otherwise keeps taking items. No state between items and no configuration.
module quaternion_to_euler_angles_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [qte_pkg::QW-1:0]    in_quat_w,
  input  logic signed [qte_pkg::QW-1:0]    in_quat_x,
  input  logic signed [qte_pkg::QW-1:0]    in_quat_y,
  input  logic signed [qte_pkg::QW-1:0]    in_quat_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_roll_angle,
  output logic signed [14:0]               out_pitch_angle,
  output logic signed [15:0]               out_yaw_angle,
  output logic                             out_pitch_clamped
);

  localparam int SW  = qte_pkg::SW;
  localparam int SPW = qte_pkg::SPW;
  localparam int RW  = qte_pkg::RW;
  localparam int RTW = qte_pkg::RTW;
  localparam int DW  = qte_pkg::DW;
  localparam int OW  = qte_pkg::OW;
  localparam int ISQ = qte_pkg::ISQ_STAGES;
  localparam int CLD = qte_pkg::ISQ_STAGES + qte_pkg::CORDIC_LAT;
  localparam int PD  = qte_pkg::PIPE_DEPTH;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic vld_r [PD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PD; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < PD; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  logic signed [SW-1:0]  sr, cr, sy, cy;
  logic signed [SPW-1:0] sp;
  logic                  clamped;
  logic [RW-1:0]         rem;
  logic [RTW-1:0]        root;

  qte_front u_front (
    .clk(clk), .en(en),
    .quat_w(in_quat_w), .quat_x(in_quat_x), .quat_y(in_quat_y), .quat_z(in_quat_z),
    .sr(sr), .cr(cr), .sy(sy), .cy(cy), .sp(sp), .clamped(clamped), .rem(rem)
  );

  qte_isqrt u_isqrt (.clk(clk), .en(en), .rem(rem), .root(root));

  // operands wait alongside the square root
  logic signed [SW-1:0]  sr_d_r [ISQ];
  logic signed [SW-1:0]  cr_d_r [ISQ];
  logic signed [SW-1:0]  sy_d_r [ISQ];
  logic signed [SW-1:0]  cy_d_r [ISQ];
  logic signed [SPW-1:0] sp_d_r [ISQ];
  logic                  cl_d_r [CLD];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_d_r[0] <= sr;
      cr_d_r[0] <= cr;
      sy_d_r[0] <= sy;
      cy_d_r[0] <= cy;
      sp_d_r[0] <= sp;
      cl_d_r[0] <= clamped;
      for (int k = 1; k < ISQ; k++) begin
        sr_d_r[k] <= sr_d_r[k-1];
        cr_d_r[k] <= cr_d_r[k-1];
        sy_d_r[k] <= sy_d_r[k-1];
        cy_d_r[k] <= cy_d_r[k-1];
        sp_d_r[k] <= sp_d_r[k-1];
      end
      for (int k = 1; k < CLD; k++) cl_d_r[k] <= cl_d_r[k-1];
    end
  end

  logic signed [OW-1:0] roll_a, pitch_a, yaw_a;

  qte_cordic u_roll (
    .clk(clk), .en(en),
    .y_in(DW'(sr_d_r[ISQ-1])), .x_in(DW'(cr_d_r[ISQ-1])), .angle(roll_a)
  );

  qte_cordic u_pitch (
    .clk(clk), .en(en),
    .y_in(DW'(sp_d_r[ISQ-1])), .x_in(DW'({1'b0, root})), .angle(pitch_a)
  );

  qte_cordic u_yaw (
    .clk(clk), .en(en),
    .y_in(DW'(sy_d_r[ISQ-1])), .x_in(DW'(cy_d_r[ISQ-1])), .angle(yaw_a)
  );

  logic signed [15:0] roll_r, yaw_r;
  logic signed [14:0] pitch_r;
  logic signed [14:0] pitch_nxt;
  logic               clamp_r;

  always_comb begin
    if (pitch_a > qte_pkg::HALF_PI_Q13)
      pitch_nxt = 15'(qte_pkg::HALF_PI_Q13);
    else if (pitch_a < -qte_pkg::HALF_PI_Q13)
      pitch_nxt = -15'(qte_pkg::HALF_PI_Q13);
    else
      pitch_nxt = 15'(pitch_a);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_a;
      yaw_r   <= yaw_a;
      pitch_r <= pitch_nxt;
      clamp_r <= cl_d_r[CLD-1];
    end
  end

  assign out_valid         = vld_r[PD-1];
  assign out_roll_angle    = roll_r;
  assign out_pitch_angle   = pitch_r;
  assign out_yaw_angle     = yaw_r;
  assign out_pitch_clamped = clamp_r;

`ifndef SYNTH
  a_clamp_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pitch_clamped |->
      out_pitch_angle == 15'sd12868 || out_pitch_angle == -15'sd12868)
    else $error("clamped pitch not at +-pi/2");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_angle <= 16'sd25736 && out_roll_angle >= -16'sd25736
      && out_yaw_angle <= 16'sd25736 && out_yaw_angle >= -16'sd25736)
    else $error("roll/yaw beyond +-pi");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[PD-2] |=> out_valid)
    else $error("item lost at output stage");
`endif

endmodule

[hdl/qte_front.sv]
module qte_front (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [qte_pkg::QW-1:0]       quat_w,
  input  logic signed [qte_pkg::QW-1:0]       quat_x,
  input  logic signed [qte_pkg::QW-1:0]       quat_y,
  input  logic signed [qte_pkg::QW-1:0]       quat_z,
  output logic signed [qte_pkg::SW-1:0]       sr,
  output logic signed [qte_pkg::SW-1:0]       cr,
  output logic signed [qte_pkg::SW-1:0]       sy,
  output logic signed [qte_pkg::SW-1:0]       cy,
  output logic signed [qte_pkg::SPW-1:0]      sp,
  output logic                                clamped,
  output logic        [qte_pkg::RW-1:0]       rem
);

  localparam int PW  = qte_pkg::PW;
  localparam int SW  = qte_pkg::SW;
  localparam int SPW = qte_pkg::SPW;
  localparam int MW  = qte_pkg::MW;
  localparam int RW  = qte_pkg::RW;

  // stage A: products
  logic signed [PW-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= quat_w * quat_x;
      yz_r <= quat_y * quat_z;
      xx_r <= quat_x * quat_x;
      yy_r <= quat_y * quat_y;
      wz_r <= quat_w * quat_z;
      xy_r <= quat_x * quat_y;
      zz_r <= quat_z * quat_z;
      wy_r <= quat_w * quat_y;
      zx_r <= quat_z * quat_x;
    end
  end

  // stage B: sums, pitch sine saturation
  logic signed [SW-2:0] s_sr, s_cr, s_sy, s_cy, s_sp;
  logic signed [SW-1:0] sr_nxt, cr_nxt, sy_nxt, cy_nxt, sp_full;
  logic signed [SPW-1:0] sp_nxt;
  logic clamp_nxt;

  always_comb begin
    s_sr = (SW-1)'(wx_r) + (SW-1)'(yz_r);
    s_cr = (SW-1)'(xx_r) + (SW-1)'(yy_r);
    s_sy = (SW-1)'(wz_r) + (SW-1)'(xy_r);
    s_cy = (SW-1)'(yy_r) + (SW-1)'(zz_r);
    s_sp = (SW-1)'(wy_r) - (SW-1)'(zx_r);
    sr_nxt  = {s_sr, 1'b0};
    cr_nxt  = qte_pkg::ONE_Q28 - {s_cr, 1'b0};
    sy_nxt  = {s_sy, 1'b0};
    cy_nxt  = qte_pkg::ONE_Q28 - {s_cy, 1'b0};
    sp_full = {s_sp, 1'b0};
    clamp_nxt = 1'b0;
    sp_nxt    = SPW'(sp_full);
    if (sp_full > qte_pkg::ONE_Q28) begin
      sp_nxt    = SPW'(qte_pkg::ONE_Q28);
      clamp_nxt = 1'b1;
    end else if (sp_full < -qte_pkg::ONE_Q28) begin
      sp_nxt    = -SPW'(qte_pkg::ONE_Q28);
      clamp_nxt = 1'b1;
    end
  end

  logic signed [SW-1:0]  sr_r [3];
  logic signed [SW-1:0]  cr_r [3];
  logic signed [SW-1:0]  sy_r [3];
  logic signed [SW-1:0]  cy_r [3];
  logic signed [SPW-1:0] sp_r [3];
  logic                  cl_r [3];

  // stage C: |s|^2
  logic [MW-1:0]   mag;
  logic [2*MW-1:0] magsq_r;
  // stage D: 1 - s^2
  logic [RW-1:0]   rem_r;

  assign mag = sp_r[0][SPW-1] ? MW'(-sp_r[0]) : MW'(sp_r[0]);

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= sr_nxt;
      cr_r[0] <= cr_nxt;
      sy_r[0] <= sy_nxt;
      cy_r[0] <= cy_nxt;
      sp_r[0] <= sp_nxt;
      cl_r[0] <= clamp_nxt;
      for (int k = 1; k < 3; k++) begin
        sr_r[k] <= sr_r[k-1];
        cr_r[k] <= cr_r[k-1];
        sy_r[k] <= sy_r[k-1];
        cy_r[k] <= cy_r[k-1];
        sp_r[k] <= sp_r[k-1];
        cl_r[k] <= cl_r[k-1];
      end
      magsq_r <= mag * mag;
      rem_r   <= (RW'(1) << (RW-1)) - magsq_r[RW-1:0];
    end
  end

  assign sr      = sr_r[2];
  assign cr      = cr_r[2];
  assign sy      = sy_r[2];
  assign cy      = cy_r[2];
  assign sp      = sp_r[2];
  assign clamped = cl_r[2];
  assign rem     = rem_r;

endmodule

[hdl/qte_isqrt.sv]
module qte_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qte_pkg::RW-1:0]      rem,
  output logic [qte_pkg::RTW-1:0]     root
);

  localparam int RW  = qte_pkg::RW;
  localparam int RTW = qte_pkg::RTW;
  localparam int N   = qte_pkg::ISQ_STAGES;

  logic [RW-1:0]  d_s [N+1];
  logic [RTW-1:0] r_s [N+1];

  assign d_s[0] = rem;
  assign r_s[0] = '0;

  // one root bit per stage, MSB first
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int SH = N - 1 - k;
    logic [RW:0]    trial, dext;
    logic           take;
    logic [RW-1:0]  d_r;
    logic [RTW-1:0] r_r;

    always_comb begin
      dext  = {1'b0, d_s[k]};
      trial = ((RW+1)'(r_s[k]) << (SH + 1)) + ((RW+1)'(1) << (2 * SH));
      take  = dext >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r <= take ? RW'(dext - trial) : d_s[k];
        r_r <= take ? (r_s[k] | (RTW'(1) << SH)) : r_s[k];
      end
    end

    assign d_s[k+1] = d_r;
    assign r_s[k+1] = r_r;
  end

  assign root = r_s[N];

endmodule

[hdl/qte_cordic.sv]
module qte_cordic (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [qte_pkg::DW-1:0]    y_in,
  input  logic signed [qte_pkg::DW-1:0]    x_in,
  output logic signed [qte_pkg::OW-1:0]    angle
);

  localparam int DW = qte_pkg::DW;
  localparam int AW = qte_pkg::AW;
  localparam int OW = qte_pkg::OW;
  localparam int N  = qte_pkg::CORDIC_STEPS;

  logic signed [DW-1:0] x_s [N+1];
  logic signed [DW-1:0] y_s [N+1];
  logic signed [AW-1:0] z_s [N+1];
  logic                 sp_s [N+1];

  // pre-rotation into the right half plane, axis cases resolved here
  logic signed [DW-1:0] x_nxt, y_nxt;
  logic signed [AW-1:0] z_nxt;
  logic                 spc_nxt;
  logic signed [DW-1:0] x0_r, y0_r;
  logic signed [AW-1:0] z0_r;
  logic                 sp0_r;

  always_comb begin
    x_nxt   = x_in;
    y_nxt   = y_in;
    z_nxt   = '0;
    spc_nxt = 1'b0;
    if (y_in == '0) begin
      spc_nxt = 1'b1;
      z_nxt   = x_in[DW-1] ? qte_pkg::PI_Q20 : '0;
    end else if (x_in == '0) begin
      spc_nxt = 1'b1;
      z_nxt   = y_in[DW-1] ? -qte_pkg::HALF_PI_Q20 : qte_pkg::HALF_PI_Q20;
    end else if (x_in[DW-1]) begin
      if (!y_in[DW-1]) begin
        x_nxt = y_in;
        y_nxt = -x_in;
        z_nxt = qte_pkg::HALF_PI_Q20;
      end else begin
        x_nxt = -y_in;
        y_nxt = x_in;
        z_nxt = -qte_pkg::HALF_PI_Q20;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r  <= x_nxt;
      y0_r  <= y_nxt;
      z0_r  <= z_nxt;
      sp0_r <= spc_nxt;
    end
  end

  assign x_s[0]  = x0_r;
  assign y_s[0]  = y0_r;
  assign z_s[0]  = z0_r;
  assign sp_s[0] = sp0_r;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [DW-1:0] x_r, y_r;
    logic signed [AW-1:0] z_r;
    logic                 sp_r;

    always_ff @(posedge clk) begin
      if (en) begin
        sp_r <= sp_s[i];
        if (sp_s[i]) begin
          x_r <= x_s[i];
          y_r <= y_s[i];
          z_r <= z_s[i];
        end else if (!y_s[i][DW-1]) begin
          x_r <= x_s[i] + (y_s[i] >>> i);
          y_r <= y_s[i] - (x_s[i] >>> i);
          z_r <= z_s[i] + qte_pkg::atan_q20(5'(i));
        end else begin
          x_r <= x_s[i] - (y_s[i] >>> i);
          y_r <= y_s[i] + (x_s[i] >>> i);
          z_r <= z_s[i] - qte_pkg::atan_q20(5'(i));
        end
      end
    end

    assign x_s[i+1]  = x_r;
    assign y_s[i+1]  = y_r;
    assign z_s[i+1]  = z_r;
    assign sp_s[i+1] = sp_r;
  end

  // Q.20 -> Q3.13, round half up, limit to +-pi
  logic signed [AW-1:0]   zr;
  logic signed [AW-8:0]   q;
  logic signed [OW-1:0]   angle_nxt;
  logic signed [OW-1:0]   angle_r;

  always_comb begin
    zr = z_s[N] + AW'(64);
    q  = (AW-7)'(zr >>> 7);
    if (q > (AW-7)'(qte_pkg::PI_Q13))
      angle_nxt = qte_pkg::PI_Q13;
    else if (q < -(AW-7)'(qte_pkg::PI_Q13))
      angle_nxt = -qte_pkg::PI_Q13;
    else
      angle_nxt = OW'(q);
  end

  always_ff @(posedge clk) begin
    if (en) angle_r <= angle_nxt;
  end

  assign angle = angle_r;

endmodule

[verif/euler_checker.sv]
module euler_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_roll_angle,
  input  logic signed [14:0] out_pitch_angle,
  input  logic signed [15:0] out_yaw_angle,
  input  logic               out_pitch_clamped,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } angles_t;

  angles_t angles_q[$];

  localparam longint ONE28 = 64'sd268435456;
  localparam longint PI20 = 3294199;
  localparam longint HPI20 = 1647099;

  function automatic longint atan_step(int i);
    longint tbl[24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
    return tbl[i];
  endfunction

  function automatic longint vector_angle(longint sy, longint sx);
    longint ang, t, xs, ys;
    ang = 0;
    if (sy == 0) return (sx < 0) ? PI20 : 0;
    if (sx == 0) return (sy > 0) ? HPI20 : -HPI20;
    if (sx < 0) begin
      t = sx;
      if (sy >= 0) begin
        sx = sy; sy = -t; ang = HPI20;
      end else begin
        sx = -sy; sy = t; ang = -HPI20;
      end
    end
    for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
      xs = sx >>> i;
      ys = sy >>> i;
      if (sy >= 0) begin
        sx = sx + ys; sy = sy - xs; ang += atan_step(i);
      end else begin
        sx = sx - ys; sy = sy + xs; ang -= atan_step(i);
      end
    end
    return ang;
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = (a + 64) >>> 7;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic angles_t predict_angles(longint w, longint x, longint y, longint z);
    angles_t e;
    longint sr, cr, sy, cy, sp, cp, mag;
    sr = 2 * (w * x + y * z);
    cr = ONE28 - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = ONE28 - 2 * (y * y + z * z);
    sp = 2 * (w * y - z * x);
    e.clamped = 1'b0;
    if (sp > ONE28) begin
      sp = ONE28; e.clamped = 1'b1;
    end else if (sp < -ONE28) begin
      sp = -ONE28; e.clamped = 1'b1;
    end
    mag = (sp < 0) ? -sp : sp;
    cp = int_sqrt((64'd1 << 56) - longint'(mag * mag));
    e.roll = 16'(round_q13(vector_angle(sr, cr), 25736));
    e.pitch = 15'(round_q13(vector_angle(sp, cp), 12868));
    e.yaw = 16'(round_q13(vector_angle(sy, cy), 25736));
    return e;
  endfunction

  initial fail_count = 0;
  assign pending_count = angles_q.size();

  always @(posedge clk) begin
    angles_t e;
    if (rst_n && in_valid && !in_stall)
      angles_q.push_back(predict_angles(in_quat_w, in_quat_x, in_quat_y, in_quat_z));
    if (rst_n && out_valid && !out_stall) begin
      if (angles_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result item");
      end else begin
        e = angles_q.pop_front();
        if (e.roll !== out_roll_angle || e.pitch !== out_pitch_angle ||
            e.yaw !== out_yaw_angle || e.clamped !== out_pitch_clamped) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch exp r=%0d p=%0d y=%0d c=%0d got r=%0d p=%0d y=%0d c=%0d",
                     e.roll, e.pitch, e.yaw, e.clamped, out_roll_angle,
                     out_pitch_angle, out_yaw_angle, out_pitch_clamped);
        end
      end
    end
  end
endmodule

[verif/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [15:0] out_roll_angle, out_yaw_angle;
  logic signed [14:0] out_pitch_angle;
  logic out_pitch_clamped;
  int fail_count, pending_count;
  int hold_cycles = 0;

  always #5 clk = ~clk;

  quaternion_to_euler_angles_top dut (.*);

  euler_checker chk (.*);

  function automatic int pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [15:0] pick_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // near-unit quaternion with random content
  task automatic random_unit(output logic signed [15:0] q[4]);
    real a[4], n;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      a[i] = $itor($signed($urandom_range(0, 20000)) - 10000);
      n += a[i] * a[i];
    end
    if (n == 0.0) begin
      a[0] = 1.0; n = 1.0;
    end
    for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(a[i] * 16384.0 / $sqrt(n)));
  endtask

  task automatic send_item(logic signed [15:0] w, x, y, z);
    int g;
    g = pick_gap();
    repeat (g) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_quat_w <= w; in_quat_x <= x; in_quat_y <= y; in_quat_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    @(posedge rst_n);
    repeat (200) @(posedge clk);
    out_stall <= 1'b1;
    hold_cycles = 0;
    while (hold_cycles < 150) begin
      @(posedge clk);
      hold_cycles++;
    end
    forever begin
      int g;
      out_stall <= 1'b0;
      @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g - 1) @(posedge clk);
        @(posedge clk);
      end
    end
  end

  initial begin
    logic signed [15:0] q[4];
    logic signed [15:0] edges[8];
    edges = '{16'sd0, 16'sd16384, -16'sd16384, 16'sh8000,
              16'sd32767, 16'sd11585, -16'sd11585, 16'sd1};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_item(16384, 0, 0, 0);
    send_item(0, 16384, 0, 0);
    send_item(0, 0, 16384, 0);
    send_item(0, 0, 0, 16384);
    send_item(-16384, 0, 0, 0);
    send_item(0, 0, 0, 0);
    send_item(11585, 0, 11585, 0);
    send_item(11585, 0, -11585, 0);
    send_item(16384, 0, 16384, 0);
    send_item(-32768, -32768, -32768, -32768);
    send_item(32767, 32767, 32767, 32767);
    send_item(-32768, 32767, -32768, 32767);
    send_item(11585, 11585, 0, 0);
    send_item(0, 0, 11585, 11585);
    send_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    for (int i = 0; i < 8; i++)
      send_item(edges[i], edges[7 - i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
    for (int n = 0; n < 1250; n++) begin
      int m;
      m = $urandom_range(0, 9);
      if (m < 7) begin
        random_unit(q);
        send_item(q[0], q[1], q[2], q[3]);
      end else
        send_item(pick_comp(m - 7), pick_comp(m - 7), pick_comp(m - 7), pick_comp(m - 7));
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end
endmodule
